### design/wah_pkg.sv
// ----------------------------------------------------------------------------
// wah_pkg: shared types and constants of the envelope-controlled wah
// Register map, register struct, multiplier widths, sine table, saturation.
// ----------------------------------------------------------------------------
package wah_pkg;

  // Serial multiplier: signed multiplicand, unsigned multiplier shifted out
  // one bit per cycle.
  localparam int unsigned MUL_A_W = 40;
  localparam int unsigned MUL_B_W = 26;
  localparam int unsigned MUL_P_W = MUL_A_W + MUL_B_W;

  localparam int unsigned ENV_W   = 24;
  localparam int unsigned CUT_W   = 15;
  localparam int unsigned COEF_W  = 16;
  localparam int unsigned STATE_W = 32;
  localparam int unsigned XS_W    = 29;

  localparam int unsigned CFG_AW  = 5;
  localparam int unsigned CFG_DW  = 32;

  localparam logic [COEF_W-1:0] UNITY_Q15   = 16'd32768;
  localparam logic [COEF_W-1:0] DAMP_MIN    = 16'd1638;
  localparam logic [CUT_W-1:0]  CUT_CEILING = 15'd31457;

  // Quarter-wave sine table, Q1.24, one guard entry at the end.
  localparam int unsigned SINE_TABLE_SIZE = 256;
  localparam int unsigned SINE_IDX_W      = $clog2(SINE_TABLE_SIZE);
  localparam int unsigned SINE_W          = 25;
  localparam logic [63:0] HALF_PI_Q30     = 64'd1686629713;
  localparam logic [63:0] Q24_ONE         = 64'd16777216;
  localparam logic [63:0] TAYLOR_DIV [8]  = '{64'd6, 64'd20, 64'd42, 64'd72,
                                              64'd110, 64'd156, 64'd210, 64'd272};

  typedef enum logic [2:0] {
    REG_SENS, REG_ATTACK, REG_RELEASE, REG_CUT_LO,
    REG_CUT_HI, REG_CUT_FLOOR, REG_DAMPING, REG_WET
  } reg_idx_e;

  typedef struct packed {
    logic [COEF_W-1:0] sens;
    logic [ENV_W-1:0]  attack;
    logic [ENV_W-1:0]  release_c;
    logic [CUT_W-1:0]  cut_lo;
    logic [CUT_W-1:0]  cut_hi;
    logic [CUT_W-1:0]  cut_floor;
    logic [COEF_W-1:0] damping;
    logic [COEF_W-1:0] wet;
  } cfg_t;

  typedef logic [SINE_W-1:0] sine_tab_t [0:SINE_TABLE_SIZE];

  function automatic sine_tab_t build_sine();
    sine_tab_t          tab;
    logic [63:0]        x;
    logic [63:0]        t;
    logic [63:0]        r;
    logic signed [63:0] sum;
    for (int i = 0; i <= SINE_TABLE_SIZE; i++) begin
      x   = (HALF_PI_Q30 * 64'(i)) / SINE_TABLE_SIZE;
      t   = x;
      sum = $signed(x);
      for (int k = 1; k <= 8; k++) begin
        t = (t * x) >> 30;
        t = (t * x) >> 30;
        t = t / TAYLOR_DIV[k-1];
        if (k[0]) begin
          sum = sum - $signed(t);
        end else begin
          sum = sum + $signed(t);
        end
      end
      if (sum < 0) begin
        sum = '0;
      end
      r = ($unsigned(sum) + 64'd32) >> 6;
      if (r > Q24_ONE) begin
        r = Q24_ONE;
      end
      tab[i] = SINE_W'(r);
    end
    return tab;
  endfunction

  localparam sine_tab_t SINE_TAB = build_sine();

  localparam logic signed [MUL_P_W-1:0] S32_MAX = 2147483647;
  localparam logic signed [MUL_P_W-1:0] S32_MIN = -S32_MAX - 1;

  function automatic logic signed [STATE_W-1:0] sat32(input logic signed [MUL_P_W-1:0] v);
    logic signed [STATE_W-1:0] r;
    if (v > S32_MAX) begin
      r = STATE_W'(S32_MAX);
    end else if (v < S32_MIN) begin
      r = STATE_W'(S32_MIN);
    end else begin
      r = STATE_W'(v);
    end
    return r;
  endfunction

endpackage

### design/wah_mul.sv
// ----------------------------------------------------------------------------
// wah_mul: bit-serial shift-add multiplier
// Signed multiplicand times unsigned multiplier, one multiplier bit a cycle.
// ----------------------------------------------------------------------------
module wah_mul (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  input  logic signed [wah_pkg::MUL_A_W-1:0]   a_i,
  input  logic        [wah_pkg::MUL_B_W-1:0]   b_i,
  output logic                                 busy_o,
  output logic                                 done_o,
  output logic signed [wah_pkg::MUL_P_W-1:0]   p_o
);

  localparam int unsigned CNT_W = $clog2(wah_pkg::MUL_B_W + 1);

  logic signed [wah_pkg::MUL_P_W-1:0] acc_q;
  logic signed [wah_pkg::MUL_P_W-1:0] a_q;
  logic        [wah_pkg::MUL_B_W-1:0] b_q;
  logic        [CNT_W-1:0]            cnt_q;
  logic                               busy_q;
  logic                               done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == CNT_W'(1));
      if (start_i) begin
        acc_q  <= '0;
        a_q    <= wah_pkg::MUL_P_W'(a_i);
        b_q    <= b_i;
        cnt_q  <= CNT_W'(wah_pkg::MUL_B_W);
        busy_q <= 1'b1;
      end else if (busy_q) begin
        if (b_q[0]) begin
          acc_q <= acc_q + a_q;
        end
        a_q   <= a_q <<< 1;
        b_q   <= b_q >> 1;
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign p_o    = acc_q;

endmodule

### design/wah_cfg.sv
// ----------------------------------------------------------------------------
// wah_cfg: APB register file
// Eight control registers, write and read back, always ready.
// ----------------------------------------------------------------------------
module wah_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel_i,
  input  logic                          penable_i,
  input  logic                          pwrite_i,
  input  logic [wah_pkg::CFG_AW-1:0]    paddr_i,
  input  logic [wah_pkg::CFG_DW-1:0]    pwdata_i,
  output logic [wah_pkg::CFG_DW-1:0]    prdata_o,
  output logic                          pready_o,
  output wah_pkg::cfg_t                 cfg_o
);

  wah_pkg::cfg_t     cfg_q;
  wah_pkg::reg_idx_e idx;

  assign idx = wah_pkg::reg_idx_e'(paddr_i[wah_pkg::CFG_AW-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sens      <= 16'd32768;
      cfg_q.attack    <= 24'd16742299;
      cfg_q.release_c <= 24'd16773721;
      cfg_q.cut_lo    <= 15'd410;
      cfg_q.cut_hi    <= 15'd4096;
      cfg_q.cut_floor <= 15'd27;
      cfg_q.damping   <= 16'd8192;
      cfg_q.wet       <= 16'd16384;
    end else if (psel_i && penable_i && pwrite_i) begin
      case (idx)
        wah_pkg::REG_SENS:      cfg_q.sens      <= pwdata_i[15:0];
        wah_pkg::REG_ATTACK:    cfg_q.attack    <= pwdata_i[23:0];
        wah_pkg::REG_RELEASE:   cfg_q.release_c <= pwdata_i[23:0];
        wah_pkg::REG_CUT_LO:    cfg_q.cut_lo    <= pwdata_i[14:0];
        wah_pkg::REG_CUT_HI:    cfg_q.cut_hi    <= pwdata_i[14:0];
        wah_pkg::REG_CUT_FLOOR: cfg_q.cut_floor <= pwdata_i[14:0];
        wah_pkg::REG_DAMPING:   cfg_q.damping   <= pwdata_i[15:0];
        wah_pkg::REG_WET:       cfg_q.wet       <= pwdata_i[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      wah_pkg::REG_SENS:      prdata_o = wah_pkg::CFG_DW'(cfg_q.sens);
      wah_pkg::REG_ATTACK:    prdata_o = wah_pkg::CFG_DW'(cfg_q.attack);
      wah_pkg::REG_RELEASE:   prdata_o = wah_pkg::CFG_DW'(cfg_q.release_c);
      wah_pkg::REG_CUT_LO:    prdata_o = wah_pkg::CFG_DW'(cfg_q.cut_lo);
      wah_pkg::REG_CUT_HI:    prdata_o = wah_pkg::CFG_DW'(cfg_q.cut_hi);
      wah_pkg::REG_CUT_FLOOR: prdata_o = wah_pkg::CFG_DW'(cfg_q.cut_floor);
      wah_pkg::REG_DAMPING:   prdata_o = wah_pkg::CFG_DW'(cfg_q.damping);
      wah_pkg::REG_WET:       prdata_o = wah_pkg::CFG_DW'(cfg_q.wet);
      default:                prdata_o = '0;
    endcase
  end

  assign pready_o = 1'b1;
  assign cfg_o    = cfg_q;

endmodule

### design/envelope_controlled_bandpass_wah.sv
// ----------------------------------------------------------------------------
// envelope_controlled_bandpass_wah: auto-wah with envelope-tuned bandpass
// Envelope follower, cutoff map, sine tuning and state-variable bandpass.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream s_axis: one signed sample per beat in tdata.
//   Output stream m_axis: one mixed sample per input beat, same format.
//   APB port: eight registers at byte addresses 0, 4, ... 28; write them only
//   while no sample is in flight.
//   Every product goes through one bit-serial multiplier that shifts out
//   one multiplier bit at a time. Ten products plus the table step and
//   the output step make up one sample; a new input beat is taken only
//   once the sequencer is back in its idle state, so samples do not
//   overlap. The multiplier loop sets the sample rate.
//   A finished sample sits in the output register; the next input beat is
//   taken while it waits. If the receiver stalls, the next result holds in
//   its final step until the output register frees.
//   Reset loads register defaults and clears envelope and filter states.
// ----------------------------------------------------------------------------
module envelope_controlled_bandpass_wah #(
  parameter int unsigned SAMPLE_BITS = 24
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   s_axis_tvalid_i,
  output logic                                   s_axis_tready_o,
  // [SAMPLE_BITS-1:0] sample_in
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]       s_axis_tdata_i,
  output logic                                   m_axis_tvalid_o,
  input  logic                                   m_axis_tready_i,
  // [SAMPLE_BITS-1:0] sample_out
  output logic [((SAMPLE_BITS+7)/8)*8-1:0]       m_axis_tdata_o,
  input  logic                                   psel_i,
  input  logic                                   penable_i,
  input  logic                                   pwrite_i,
  input  logic [wah_pkg::CFG_AW-1:0]             paddr_i,
  input  logic [wah_pkg::CFG_DW-1:0]             pwdata_i,
  output logic [wah_pkg::CFG_DW-1:0]             prdata_o,
  output logic                                   pready_o
);

  localparam int unsigned TDATA_W = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int unsigned LVL_SH  = SAMPLE_BITS - 10;
  localparam int unsigned Y_SH    = 43 - SAMPLE_BITS;
  localparam int unsigned POS_W   = wah_pkg::CUT_W + wah_pkg::SINE_IDX_W + 1;
  localparam int unsigned A_W     = wah_pkg::MUL_A_W;
  localparam int unsigned B_W     = wah_pkg::MUL_B_W;
  localparam int unsigned P_W     = wah_pkg::MUL_P_W;

  localparam logic signed [P_W-1:0] ENV_MAX  = (64'sd1 <<< wah_pkg::ENV_W) - 64'sd1;
  localparam logic signed [P_W-1:0] ENV_HALF = 64'sd1 <<< (wah_pkg::ENV_W - 1);
  localparam logic signed [P_W-1:0] Y_MAX    = (64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1;
  localparam logic signed [P_W-1:0] Y_MIN    = -Y_MAX - 1;

  typedef enum logic [3:0] {
    S_IDLE, S_LEVEL, S_ENV1, S_ENV2, S_CUT, S_TAB, S_SIN,
    S_LOW, S_DAMP, S_BAND, S_MIXD, S_MIXW, S_FIN
  } state_e;

  wah_pkg::cfg_t cfg;

  wah_cfg u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel_i    (psel_i),
    .penable_i (penable_i),
    .pwrite_i  (pwrite_i),
    .paddr_i   (paddr_i),
    .pwdata_i  (pwdata_i),
    .prdata_o  (prdata_o),
    .pready_o  (pready_o),
    .cfg_o     (cfg)
  );

  state_e                              state_q;
  logic                                issued_q;
  logic        [SAMPLE_BITS-1:0]       mag_q;
  logic signed [wah_pkg::XS_W-1:0]     xs_q;
  logic        [wah_pkg::ENV_W-1:0]    level_q;
  logic        [wah_pkg::ENV_W-1:0]    env_q;
  logic signed [P_W-1:0]               acc_q;
  logic        [wah_pkg::SINE_IDX_W-1:0] idx_q;
  logic        [15:0]                  frac_q;
  logic        [wah_pkg::SINE_W-1:0]   s0_q;
  logic        [wah_pkg::SINE_W-1:0]   d_q;
  logic        [wah_pkg::SINE_W:0]     f_q;
  logic signed [wah_pkg::STATE_W-1:0]  low_q;
  logic signed [wah_pkg::STATE_W-1:0]  band_q;
  logic signed [A_W-1:0]               hp_q;
  logic        [SAMPLE_BITS-1:0]       y_q;
  logic                                m_valid_q;
  logic                                fin_fire;

  // Input decode
  logic signed [SAMPLE_BITS-1:0]   x_in;
  logic        [SAMPLE_BITS-1:0]   mag_in;
  logic signed [wah_pkg::XS_W-1:0] xs_in;

  assign x_in   = $signed(s_axis_tdata_i[SAMPLE_BITS-1:0]);
  assign mag_in = x_in[SAMPLE_BITS-1] ? SAMPLE_BITS'(-x_in) : SAMPLE_BITS'(x_in);

  generate
    if (SAMPLE_BITS <= 28) begin : g_xs_up
      assign xs_in = wah_pkg::XS_W'(x_in) <<< (28 - SAMPLE_BITS);
    end else begin : g_xs_dn
      assign xs_in = wah_pkg::XS_W'(x_in >>> (SAMPLE_BITS - 28));
    end
  endgenerate

  // Register clamps
  logic [wah_pkg::COEF_W-1:0] sens_c, q_c, wet_c, dry_c;
  logic [wah_pkg::CUT_W-1:0]  lo_c, hi_c;
  logic [wah_pkg::ENV_W-1:0]  coef_sel;

  assign sens_c   = (cfg.sens > wah_pkg::UNITY_Q15) ? wah_pkg::UNITY_Q15 : cfg.sens;
  assign wet_c    = (cfg.wet > wah_pkg::UNITY_Q15) ? wah_pkg::UNITY_Q15 : cfg.wet;
  assign dry_c    = wah_pkg::UNITY_Q15 - wet_c;
  assign q_c      = (cfg.damping < wah_pkg::DAMP_MIN) ? wah_pkg::DAMP_MIN :
                    (cfg.damping > wah_pkg::UNITY_Q15) ? wah_pkg::UNITY_Q15 : cfg.damping;
  assign lo_c     = (cfg.cut_lo > cfg.cut_hi) ? cfg.cut_hi : cfg.cut_lo;
  assign hi_c     = (cfg.cut_lo > cfg.cut_hi) ? cfg.cut_lo : cfg.cut_hi;
  assign coef_sel = (level_q > env_q) ? cfg.attack : cfg.release_c;

  // Shared multiplier
  logic                  mul_start, mul_busy, mul_done, is_mul;
  logic signed [A_W-1:0] mul_a;
  logic        [B_W-1:0] mul_b;
  logic signed [P_W-1:0] prod;

  assign is_mul    = (state_q != S_IDLE) && (state_q != S_TAB) && (state_q != S_FIN);
  assign mul_start = is_mul && !issued_q;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_LEVEL: begin mul_a = A_W'(mag_q);    mul_b = B_W'(sens_c); end
      S_ENV1:  begin mul_a = A_W'(env_q);    mul_b = B_W'(coef_sel); end
      S_ENV2:  begin
        mul_a = A_W'(level_q);
        mul_b = (B_W'(1) << wah_pkg::ENV_W) - B_W'(coef_sel);
      end
      S_CUT:   begin mul_a = A_W'(env_q);    mul_b = B_W'(hi_c - lo_c); end
      S_SIN:   begin mul_a = A_W'(d_q);      mul_b = B_W'(frac_q); end
      S_LOW:   begin mul_a = A_W'(band_q);   mul_b = B_W'(f_q); end
      S_DAMP:  begin mul_a = A_W'(band_q);   mul_b = B_W'(q_c); end
      S_BAND:  begin mul_a = hp_q;           mul_b = B_W'(f_q); end
      S_MIXD:  begin mul_a = A_W'(xs_q);     mul_b = B_W'(dry_c); end
      S_MIXW:  begin mul_a = A_W'(band_q);   mul_b = B_W'(wet_c); end
      default: begin mul_a = '0;             mul_b = '0; end
    endcase
  end

  wah_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .busy_o  (mul_busy),
    .done_o  (mul_done),
    .p_o     (prod)
  );

  // Per-step results
  logic signed [P_W-1:0]              lvl_sh, env_sh, y_sh;
  logic        [wah_pkg::ENV_W-1:0]   level_d, env_d;
  logic        [wah_pkg::CUT_W+1:0]   w_raw, w_fl, w_cl;
  logic        [POS_W-1:0]            pos;
  logic        [wah_pkg::SINE_W-1:0]  s_d, s1;
  logic        [SAMPLE_BITS-1:0]      y_d;

  always_comb begin
    lvl_sh  = prod >>> LVL_SH;
    level_d = (lvl_sh > ENV_MAX) ? '1 : lvl_sh[wah_pkg::ENV_W-1:0];
    env_sh  = (acc_q + prod + ENV_HALF) >>> wah_pkg::ENV_W;
    env_d   = (env_sh > ENV_MAX) ? '1 : env_sh[wah_pkg::ENV_W-1:0];
    w_raw   = (wah_pkg::CUT_W+2)'(lo_c) + (wah_pkg::CUT_W+2)'(prod >>> wah_pkg::ENV_W);
    w_fl    = (w_raw < (wah_pkg::CUT_W+2)'(cfg.cut_floor)) ?
              (wah_pkg::CUT_W+2)'(cfg.cut_floor) : w_raw;
    w_cl    = (w_fl > (wah_pkg::CUT_W+2)'(wah_pkg::CUT_CEILING)) ?
              (wah_pkg::CUT_W+2)'(wah_pkg::CUT_CEILING) : w_fl;
    pos     = {w_cl[wah_pkg::CUT_W-1:0], {(wah_pkg::SINE_IDX_W+1){1'b0}}};
    s1      = wah_pkg::SINE_TAB[(wah_pkg::SINE_IDX_W+1)'(idx_q) + (wah_pkg::SINE_IDX_W+1)'(1)];
    s_d     = s0_q + wah_pkg::SINE_W'(prod >>> 16);
    y_sh    = acc_q >>> Y_SH;
    y_d     = (y_sh > Y_MAX) ? SAMPLE_BITS'(Y_MAX) :
              (y_sh < Y_MIN) ? SAMPLE_BITS'(Y_MIN) : y_sh[SAMPLE_BITS-1:0];
  end

  assign fin_fire = (state_q == S_FIN) && (!m_valid_q || m_axis_tready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      issued_q  <= 1'b0;
      env_q     <= '0;
      low_q     <= '0;
      band_q    <= '0;
      m_valid_q <= 1'b0;
    end else begin
      if (fin_fire) begin
        m_valid_q <= 1'b1;
      end else if (m_valid_q && m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
      if (mul_start) begin
        issued_q <= 1'b1;
      end else if (mul_done) begin
        issued_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (s_axis_tvalid_i) begin
            mag_q   <= mag_in;
            xs_q    <= xs_in;
            state_q <= S_LEVEL;
          end
        end
        S_LEVEL: if (mul_done) begin
          level_q <= level_d;
          state_q <= S_ENV1;
        end
        S_ENV1: if (mul_done) begin
          acc_q   <= prod;
          state_q <= S_ENV2;
        end
        S_ENV2: if (mul_done) begin
          env_q   <= env_d;
          state_q <= S_CUT;
        end
        S_CUT: if (mul_done) begin
          idx_q   <= pos[POS_W-1:16];
          frac_q  <= pos[15:0];
          state_q <= S_TAB;
        end
        S_TAB: begin
          s0_q    <= wah_pkg::SINE_TAB[(wah_pkg::SINE_IDX_W+1)'(idx_q)];
          d_q     <= (s1 > wah_pkg::SINE_TAB[(wah_pkg::SINE_IDX_W+1)'(idx_q)]) ?
                     s1 - wah_pkg::SINE_TAB[(wah_pkg::SINE_IDX_W+1)'(idx_q)] : '0;
          state_q <= S_SIN;
        end
        S_SIN: if (mul_done) begin
          f_q     <= {s_d, 1'b0};
          state_q <= S_LOW;
        end
        S_LOW: if (mul_done) begin
          low_q   <= wah_pkg::sat32(P_W'(low_q) + (prod >>> wah_pkg::ENV_W));
          state_q <= S_DAMP;
        end
        S_DAMP: if (mul_done) begin
          hp_q    <= A_W'(xs_q) - A_W'(low_q) - A_W'(prod >>> 14);
          state_q <= S_BAND;
        end
        S_BAND: if (mul_done) begin
          band_q  <= wah_pkg::sat32(P_W'(band_q) + (prod >>> wah_pkg::ENV_W));
          state_q <= S_MIXD;
        end
        S_MIXD: if (mul_done) begin
          acc_q   <= prod;
          state_q <= S_MIXW;
        end
        S_MIXW: if (mul_done) begin
          acc_q   <= acc_q + prod;
          state_q <= S_FIN;
        end
        S_FIN: begin
          // hold until the output register frees
          if (fin_fire) begin
            y_q     <= y_d;
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = TDATA_W'(y_q);

  // Assertions
  a_idle_no_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !mul_done)
    else $error("multiplier finished while sequencer idle");

  a_start_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_start |-> !mul_busy)
    else $error("multiplier started while busy");

  a_valid_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(state_q == S_FIN))
    else $error("output valid raised outside final step");

endmodule

### test/envelope_controlled_bandpass_wah_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// envelope_controlled_bandpass_wah_tb: self-checking bench for the auto-wah
// Streams signed samples through the wah and checks every output beat
// against a bit-exact predictor of the envelope follower, sine tuning and
// state-variable bandpass, across several register settings and idle modes.
// ----------------------------------------------------------------------------
module envelope_controlled_bandpass_wah_tb;

  localparam int SW        = 24;
  localparam int SETTLE    = 320;
  localparam int WDOG_MAX  = 5000;
  localparam int NUM_PHASE = 7;
  localparam int PHASE_LEN = 150;
  localparam int TAB_N     = wah_pkg::SINE_TABLE_SIZE;
  localparam longint S32_HI = 64'sh0000_0000_7FFF_FFFF;
  localparam longint S32_LO = -64'sh0000_0000_8000_0000;

  typedef struct {
    bit              hold;
    logic [SW-1:0]   smp;
  } stim_t;

  logic           clk_i = 1'b0;
  logic           rst_ni = 1'b0;
  logic           s_valid = 1'b0;
  logic           s_ready;
  logic [SW-1:0]  s_data = '0;
  logic           m_valid;
  logic           m_ready = 1'b0;
  logic [SW-1:0]  m_data;
  logic           psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [wah_pkg::CFG_AW-1:0] paddr = '0;
  logic [wah_pkg::CFG_DW-1:0] pwdata = '0;
  logic [wah_pkg::CFG_DW-1:0] prdata;
  logic           pready;

  stim_t          sample_backlog[$];
  logic [SW-1:0]  expected_out[$];
  logic           in_taken = 1'b0;
  int             send_idle = 0, recv_idle = 0;
  int             mismatches = 0;
  int             idle_cycles = 0;

  // predictor state and register shadow
  longint unsigned sine_q24 [0:TAB_N];
  longint unsigned reg_shadow [8];
  longint unsigned env_lvl;
  longint          lp_st, bp_st;

  envelope_controlled_bandpass_wah dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .psel_i          (psel),
    .penable_i       (penable),
    .pwrite_i        (pwrite),
    .paddr_i         (paddr),
    .pwdata_i        (pwdata),
    .prdata_o        (prdata),
    .pready_o        (pready)
  );

  always #6 clk_i = ~clk_i;

  function automatic longint unsigned reg_mask(int idx);
    case (wah_pkg::reg_idx_e'(idx))
      wah_pkg::REG_ATTACK, wah_pkg::REG_RELEASE: return 64'hFF_FFFF;
      wah_pkg::REG_CUT_LO, wah_pkg::REG_CUT_HI,
      wah_pkg::REG_CUT_FLOOR:                    return 64'h7FFF;
      default:                                   return 64'hFFFF;
    endcase
  endfunction

  task automatic fill_sine_q24();
    longint unsigned x, t, r, dv;
    longint          acc;
    for (int i = 0; i <= TAB_N; i++) begin
      x   = (64'd1686629713 * longint'(i)) / TAB_N;
      t   = x;
      acc = longint'(x);
      for (int k = 1; k <= 8; k++) begin
        dv = (2 * k) * (2 * k + 1);
        t  = (t * x) >> 30;
        t  = (t * x) >> 30;
        t  = t / dv;
        if (k % 2 == 1) acc = acc - longint'(t);
        else acc = acc + longint'(t);
      end
      if (acc < 0) acc = 0;
      r = (longint'(acc) + 32) >> 6;
      if (r > 64'd16777216) r = 64'd16777216;
      sine_q24[i] = r;
    end
  endtask

  function automatic logic [SW-1:0] wah_predict(logic [SW-1:0] raw);
    longint          x, xs, hp, y, lo_sum;
    longint unsigned mag, lvl, c, w, pos, idx, frac, s0, s1, s, f, sens, q, wet, dry;
    longint unsigned lo_c, hi_c, tmp;
    x    = longint'($signed(raw));
    sens = (reg_shadow[wah_pkg::REG_SENS] > 32768) ? 32768 : reg_shadow[wah_pkg::REG_SENS];
    mag  = (x < 0) ? longint'(-x) : longint'(x);
    lvl  = (mag * sens) >> (SW - 10);
    if (lvl > 64'hFF_FFFF) lvl = 64'hFF_FFFF;
    c = (lvl > env_lvl) ? reg_shadow[wah_pkg::REG_ATTACK] : reg_shadow[wah_pkg::REG_RELEASE];
    env_lvl = (c * env_lvl + (64'd16777216 - c) * lvl + 64'd8388608) >> 24;
    if (env_lvl > 64'hFF_FFFF) env_lvl = 64'hFF_FFFF;

    lo_c = reg_shadow[wah_pkg::REG_CUT_LO];
    hi_c = reg_shadow[wah_pkg::REG_CUT_HI];
    if (lo_c > hi_c) begin
      tmp = lo_c; lo_c = hi_c; hi_c = tmp;
    end
    w = lo_c + ((env_lvl * (hi_c - lo_c)) >> 24);
    if (w < reg_shadow[wah_pkg::REG_CUT_FLOOR]) w = reg_shadow[wah_pkg::REG_CUT_FLOOR];
    if (w > 31457) w = 31457;

    pos  = w * 2 * TAB_N;
    idx  = pos >> 16;
    frac = pos & 64'hFFFF;
    if (idx >= TAB_N) begin
      idx = TAB_N - 1; frac = 64'hFFFF;
    end
    s0 = sine_q24[idx];
    s1 = sine_q24[idx + 1];
    s  = (s1 > s0) ? s0 + (((s1 - s0) * frac) >> 16) : s0;
    f  = s << 1;

    q = reg_shadow[wah_pkg::REG_DAMPING];
    if (q < 1638) q = 1638;
    if (q > 32768) q = 32768;
    xs = x <<< (28 - SW);
    lo_sum = lp_st + ((longint'(f) * bp_st) >>> 24);
    lp_st  = (lo_sum > S32_HI) ? S32_HI :
             (lo_sum < S32_LO) ? S32_LO : lo_sum;
    hp = xs - lp_st - ((longint'(q) * bp_st) >>> 14);
    lo_sum = bp_st + ((longint'(f) * hp) >>> 24);
    bp_st  = (lo_sum > S32_HI) ? S32_HI :
             (lo_sum < S32_LO) ? S32_LO : lo_sum;

    wet = (reg_shadow[wah_pkg::REG_WET] > 32768) ? 32768 : reg_shadow[wah_pkg::REG_WET];
    dry = 32768 - wet;
    y = (xs * longint'(dry) + bp_st * longint'(wet)) >>> (43 - SW);
    if (y > 8388607) y = 8388607;
    if (y < -8388608) y = -8388608;
    return y[SW-1:0];
  endfunction

  // predict on input beats, check output beats
  always @(posedge clk_i) begin : scoreboard
    logic [SW-1:0] want;
    in_taken <= s_valid && s_ready;
    if (rst_ni) begin
      if (s_valid && s_ready) expected_out.push_back(wah_predict(s_data));
      if (m_valid && m_ready) begin
        if (expected_out.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected output beat %h", m_data);
        end else begin
          want = expected_out.pop_front();
          if (m_data !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("sample_out mismatch: expected %h, got %h", want, m_data);
          end
        end
      end
      if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WDOG_MAX) begin
        $display("envelope_controlled_bandpass_wah_tb NOT OK");
        $finish;
      end
    end
  end

  // source side: advance on the beat, hold otherwise
  always @(negedge clk_i) begin : source_drv
    logic          nv;
    logic [SW-1:0] nd;
    stim_t         st;
    nv = s_valid;
    nd = s_data;
    if (rst_ni && (!s_valid || in_taken)) begin
      nv = 1'b0;
      if (sample_backlog.size() != 0) begin
        if (sample_backlog[0].hold) begin
          if (expected_out.size() == 0) void'(sample_backlog.pop_front());
        end else if ($urandom_range(99) >= send_idle) begin
          st = sample_backlog.pop_front();
          nd = st.smp;
          nv = 1'b1;
        end
      end
    end
    s_valid <= nv;
    s_data  <= nd;
    m_ready <= rst_ni && ($urandom_range(99) >= recv_idle);
  end

  task automatic reg_write(wah_pkg::reg_idx_e idx, logic [wah_pkg::CFG_DW-1:0] val);
    @(negedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= wah_pkg::CFG_AW'(4 * int'(idx)); pwdata <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    reg_shadow[idx] = val & reg_mask(idx);
  endtask

  task automatic push_sample(logic [SW-1:0] v);
    stim_t st;
    st.hold = 1'b0;
    st.smp  = v;
    sample_backlog.push_back(st);
  endtask

  task automatic wait_drained();
    while (sample_backlog.size() != 0 || s_valid || expected_out.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic program_phase(int ph);
    logic [wah_pkg::CFG_DW-1:0] v [8];
    case (ph)
      2: v = '{32'hFFFF, 32'h0, 32'h0, 32'h7FFF, 32'h0, 32'h7FFF, 32'hFFFF, 32'hFFFF};
      3: v = '{32'h0, 32'hFF_FFFF, 32'hFF_FFFF, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0};
      4: for (int i = 0; i < 8; i++) v[i] = $urandom();
      default: begin
        v[wah_pkg::REG_SENS]      = $urandom_range(32768, 4096);
        v[wah_pkg::REG_ATTACK]    = $urandom_range(16777215, 8000000);
        v[wah_pkg::REG_RELEASE]   = $urandom_range(16777215, 14000000);
        v[wah_pkg::REG_CUT_LO]    = $urandom_range(31457);
        v[wah_pkg::REG_CUT_HI]    = $urandom_range(31457);
        v[wah_pkg::REG_CUT_FLOOR] = $urandom_range(2000);
        v[wah_pkg::REG_DAMPING]   = $urandom_range(32768, 1638);
        v[wah_pkg::REG_WET]       = $urandom_range(32768);
      end
    endcase
    for (int i = 0; i < 8; i++) reg_write(wah_pkg::reg_idx_e'(i), v[i]);
  endtask

  task automatic queue_random(int n);
    int  amp, per, k;
    bit  neg;
    k = 0;
    while (k < n) begin
      case ($urandom_range(9))
        0, 1, 2: begin
          push_sample(SW'($urandom()));
          k++;
        end
        3: begin
          for (int j = 0; j < 12 && k < n; j++, k++) push_sample('0);
        end
        default: begin
          // tone burst: sawtooth ramps of alternating sign at random level and period
          amp = $urandom_range(8388607);
          per = $urandom_range(32, 2);
          neg = 1'b0;
          for (int j = 0; j < 3 * per && k < n; j++, k++) begin
            if (j % per == 0) neg = ~neg;
            push_sample(neg ? SW'(-(amp * (j % per) / per))
                            : SW'(amp * (j % per) / per));
          end
        end
      endcase
    end
  endtask

  initial begin : stimulus
    stim_t hs;
    fill_sine_q24();
    reg_shadow = '{32768, 16742299, 16773721, 410, 4096, 27, 8192, 16384};
    env_lvl = 0; lp_st = 0; bp_st = 0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    for (int ph = 0; ph < NUM_PHASE; ph++) begin
      send_idle = (ph < 2) ? 14 : (ph < 4) ? 65 : 0;
      recv_idle = (ph < 2) ? 65 : (ph < 4) ? 14 : 0;
      if (ph != 0) program_phase(ph);
      if (ph == 0) begin
        // extremes and sign edges, full-scale alternation, then a full-scale step to push saturation
        push_sample(24'h000000); push_sample(24'h7FFFFF); push_sample(24'h800000);
        push_sample(24'hFFFFFF); push_sample(24'h000001); push_sample(24'h800001);
        for (int j = 0; j < 8; j++) push_sample(j[0] ? 24'h800000 : 24'h7FFFFF);
        for (int j = 0; j < 6; j++) push_sample(24'h7FFFFF);
        for (int j = 0; j < 4; j++) push_sample(24'h000000);
      end
      queue_random(PHASE_LEN / 2);
      if (ph == 1) begin
        hs.hold = 1'b1;
        hs.smp  = '0;
        sample_backlog.push_back(hs);
      end
      queue_random(PHASE_LEN - PHASE_LEN / 2);
      wait_drained();
    end

    if (mismatches == 0) begin
      $display("envelope_controlled_bandpass_wah_tb OK");
    end else begin
      $display("envelope_controlled_bandpass_wah_tb NOT OK");
    end
    $finish;
  end

endmodule
